/* hw/rtl/ldps_pkg.sv */
`timescale 1ns / 1ps

package ldps_pkg;

  localparam int unsigned LANES     = 4;
  localparam int unsigned MAX_LANES = 4;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned PROD_W    = 2 * ELEM_W;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned BEAT_W    = MAX_LANES * ELEM_W;
  localparam int unsigned RES_W     = 16;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [ACC_W-1:0]         acc_t;
  typedef logic signed [RES_W-1:0]  res_t;

  typedef struct packed {
    logic mul_load;
    logic acc_take;
    logic acc_start;
    logic acc_last;
  } lane_ctl_t;

  // clamp a signed accumulator to the signed element range
  function automatic elem_t sat_elem(acc_t v);
    logic fits;
    elem_t r;
    fits = (&v[ACC_W-1:ELEM_W-1]) | ~(|v[ACC_W-1:ELEM_W-1]);
    if (fits) begin
      r = elem_t'(v[ELEM_W-1:0]);
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ELEM_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/ldps_if.sv */
`timescale 1ns / 1ps

interface ldps_in_if;
  import ldps_pkg::*;
  logic              valid;
  logic              ready;
  logic [BEAT_W-1:0] a_lanes;
  logic [BEAT_W-1:0] b_lanes;
  logic              last_beat;

  modport source (output valid, output a_lanes, output b_lanes, output last_beat,
                  input ready);
  modport sink   (input valid, input a_lanes, input b_lanes, input last_beat,
                  output ready);
endinterface

interface ldps_out_if;
  import ldps_pkg::*;
  logic valid;
  logic ready;
  res_t dot_result;

  modport source (output valid, output dot_result, input ready);
  modport sink   (input valid, input dot_result, output ready);
endinterface

/* hw/rtl/ldps_lane.sv */
`timescale 1ns / 1ps

module ldps_lane
  import ldps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  elem_t     a_i,
  input  elem_t     b_i,
  output elem_t     clamp_o
);

  prod_t prod_d, prod_q;
  acc_t  acc_d, acc_q;
  acc_t  prod_ext;
  elem_t clamp_q;

  assign prod_d   = a_i * b_i;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = ctl_i.acc_start ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_load) begin
      prod_q <= prod_d;
    end
    if (ctl_i.acc_take && ctl_i.acc_last) begin
      clamp_q <= sat_elem(acc_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctl_i.acc_take) begin
      acc_q <= ctl_i.acc_last ? '0 : acc_d;
    end
  end

  assign clamp_o = clamp_q;

endmodule

/* hw/rtl/ldps_merge.sv */
`timescale 1ns / 1ps

module ldps_merge
  import ldps_pkg::*;
(
  input  logic  clk_i,
  input  logic  load_i,
  input  elem_t clamp_i [LANES],
  output res_t  dot_result_o
);

  res_t sum_d, sum_q;

  always_comb begin
    sum_d = '0;
    for (int unsigned i = 0; i < LANES; i++) begin
      sum_d = sum_d + res_t'(clamp_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sum_q <= sum_d;
    end
  end

  assign dot_result_o = sum_q;

endmodule

/* hw/rtl/int16_lane_dot_product_saturate_unit.sv */
`timescale 1ns / 1ps

// Lane-parallel signed 16-bit dot product with per-lane saturation.
// in_i carries one beat per transaction: LANES packed A and B elements
// (lane 0 in the low bits) and last_beat, which closes a group.
// out_o carries one transaction per group: the wrapped 16-bit sum of the
// lane accumulators, each clamped to the signed 16-bit range.
// Each lane multiplies, then adds into its own 48-bit wrapping accumulator;
// the first beat of a group loads the product instead.
// Throughput: one beat per cycle while in_i.ready stays high. A last beat
// passes the multiply register, then the accumulate and clamp register,
// then the lane-sum output register, before its result shows on out_o.
// Reset clears all accumulators and control; the next beat starts a group.
// When out_o stalls, beats keep being taken until a last beat waits in the
// multiply register behind full clamp and output registers, then in_i.ready
// drops until out_o drains.

module int16_lane_dot_product_saturate_unit
  import ldps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  ldps_in_if.sink    in_i,
  ldps_out_if.source out_o
);

  logic      m_v_q, m_last_q;
  logic      c_v_q, o_v_q;
  logic      grp_open_q;
  logic      in_acc, out_acc;
  logic      o_can, c_can, c_adv, acc_take;
  lane_ctl_t ctl;
  elem_t     clamp [LANES];

  assign out_acc  = o_v_q && out_o.ready;
  assign o_can    = !o_v_q || out_o.ready;
  assign c_adv    = c_v_q && o_can;
  assign c_can    = !c_v_q || o_can;
  assign acc_take = m_v_q && (!m_last_q || c_can);
  assign in_i.ready = !m_v_q || acc_take;
  assign in_acc   = in_i.valid && in_i.ready;

  assign ctl.mul_load  = in_acc;
  assign ctl.acc_take  = acc_take;
  assign ctl.acc_start = !grp_open_q;
  assign ctl.acc_last  = m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q      <= 1'b0;
      m_last_q   <= 1'b0;
      c_v_q      <= 1'b0;
      o_v_q      <= 1'b0;
      grp_open_q <= 1'b0;
    end else begin
      if (in_acc) begin
        m_v_q    <= 1'b1;
        m_last_q <= in_i.last_beat;
      end else if (acc_take) begin
        m_v_q <= 1'b0;
      end
      if (acc_take) begin
        grp_open_q <= !m_last_q;
      end
      if (acc_take && m_last_q) begin
        c_v_q <= 1'b1;
      end else if (c_adv) begin
        c_v_q <= 1'b0;
      end
      if (c_adv) begin
        o_v_q <= 1'b1;
      end else if (out_acc) begin
        o_v_q <= 1'b0;
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ldps_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .a_i     (elem_t'(in_i.a_lanes[g*ELEM_W +: ELEM_W])),
      .b_i     (elem_t'(in_i.b_lanes[g*ELEM_W +: ELEM_W])),
      .clamp_o (clamp[g])
    );
  end

  ldps_merge u_merge (
    .clk_i        (clk_i),
    .load_i       (c_adv),
    .clamp_i      (clamp),
    .dot_result_o (out_o.dot_result)
  );

  assign out_o.valid = o_v_q;

endmodule

/* hw/rtl/ldps_chk.sv */
`timescale 1ns / 1ps

module ldps_chk
  import ldps_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input res_t out_data_i
);

  logic       in_acc, out_acc;
  logic [2:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // track closed groups whose result has not been taken yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_acc && in_last_i) - 3'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 3'd0)
    else $error("result without a closed group");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("too many closed groups in flight");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd3 && !out_ready_i |-> !in_ready_i)
    else $error("beat taken with every stage full");

endmodule

bind int16_lane_dot_product_saturate_unit ldps_chk u_ldps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_beat),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.dot_result)
);
